FILE: hdl/cif_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_pkg: shared types and constants of the complex IIR filter
// Sample and coefficient formats, accumulator widths, register indexes and
// the rounding / saturation function used by both real and imaginary paths.
// ----------------------------------------------------------------------------
package cif_pkg;

  // Filter geometry and number formats
  localparam int ORDER       = 3;
  localparam int SAMPLE_BITS = 16;               // Q1.15 samples
  localparam int COEF_BITS   = 18;               // Q4.14 coefficients
  localparam int FRAC_SHIFT  = COEF_BITS - 4;    // extra fraction bits of a product
  localparam int NUM_TAPS    = 4;                // b0..b3 registers
  localparam int DEN_TAPS    = 3;                // a1..a3 registers

  // Arithmetic widths
  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;   // one product
  localparam int FF_W   = PROD_W + 2;                // sum of up to four products
  localparam int FB_W   = PROD_W + 1;                // sum of up to two products
  localparam int ACC_W  = PROD_W + 4;                // full recursion sum
  localparam int SH_W   = ACC_W - FRAC_SHIFT;        // accumulator after the shift

  typedef logic signed [SAMPLE_BITS-1:0] samp_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]      prod_t;
  typedef logic signed [FF_W-1:0]        ff_t;
  typedef logic signed [FB_W-1:0]        fb_t;
  typedef logic signed [ACC_W-1:0]       acc_t;

  // Configuration register map
  localparam int REG_W = 3;
  typedef logic [REG_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_NUM_COEF_0 = 3'd0;
  localparam reg_idx_t REG_NUM_COEF_1 = 3'd1;
  localparam reg_idx_t REG_NUM_COEF_2 = 3'd2;
  localparam reg_idx_t REG_NUM_COEF_3 = 3'd3;
  localparam reg_idx_t REG_DEN_COEF_1 = 3'd4;
  localparam reg_idx_t REG_DEN_COEF_2 = 3'd5;
  localparam reg_idx_t REG_DEN_COEF_3 = 3'd6;

  // b0 resets to 1.0, everything else to zero
  localparam coef_t NUM_COEF_0_RESET = coef_t'(2 ** FRAC_SHIFT);

  // Rounding and saturation constants
  localparam acc_t  ROUND_ADD = acc_t'(2 ** (FRAC_SHIFT - 1));
  localparam samp_t SAMP_MAX  = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam samp_t SAMP_MIN  = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    samp_t y;
    logic  clip;
  } sat_t;

  // Round to nearest (ties up), drop the fraction bits, saturate to a sample
  function automatic sat_t round_sat(acc_t a);
    acc_t            r;
    logic [SH_W-1:0] s;
    sat_t            o;
    r = a + ROUND_ADD;
    s = r[ACC_W-1:FRAC_SHIFT];
    if ((&s[SH_W-1:SAMPLE_BITS-1]) || !(|s[SH_W-1:SAMPLE_BITS-1])) begin
      o.y    = s[SAMPLE_BITS-1:0];
      o.clip = 1'b0;
    end else begin
      o.y    = s[SH_W-1] ? SAMP_MIN : SAMP_MAX;
      o.clip = 1'b1;
    end
    return o;
  endfunction

endpackage

FILE: hdl/cif_tap.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_tap: one delay cell of the filter history
// Holds one past input and one past output sample (real and imaginary),
// passes them to the next cell on each shift and forms its feedforward
// products. A clear zeroes what the cell hands on and contributes.
// ----------------------------------------------------------------------------
module cif_tap (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            x_shift_i,
  input  logic            x_clr_i,
  input  logic            y_shift_i,
  input  logic            y_clr_i,
  input  cif_pkg::samp_t  x_re_i,
  input  cif_pkg::samp_t  x_im_i,
  input  cif_pkg::samp_t  y_re_i,
  input  cif_pkg::samp_t  y_im_i,
  input  cif_pkg::coef_t  num_i,
  output cif_pkg::samp_t  x_re_o,
  output cif_pkg::samp_t  x_im_o,
  output cif_pkg::samp_t  y_re_o,
  output cif_pkg::samp_t  y_im_o,
  output cif_pkg::prod_t  prod_re_o,
  output cif_pkg::prod_t  prod_im_o
);

  cif_pkg::samp_t x_re_q, x_im_q;
  cif_pkg::samp_t y_re_q, y_im_q;

  // Input history, advances once per accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_re_q <= '0;
      x_im_q <= '0;
    end else if (x_shift_i) begin
      x_re_q <= x_re_i;
      x_im_q <= x_im_i;
    end
  end

  // Output history, advances once per produced result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_re_q <= '0;
      y_im_q <= '0;
    end else if (y_shift_i) begin
      y_re_q <= y_re_i;
      y_im_q <= y_im_i;
    end
  end

  // Cleared history reads as zero
  assign x_re_o = x_clr_i ? '0 : x_re_q;
  assign x_im_o = x_clr_i ? '0 : x_im_q;
  assign y_re_o = y_clr_i ? '0 : y_re_q;
  assign y_im_o = y_clr_i ? '0 : y_im_q;

  // Feedforward products of this tap
  assign prod_re_o = num_i * x_re_o;
  assign prod_im_o = num_i * x_im_o;

endmodule

FILE: hdl/cif_recur.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cif_recur: feedback recursion of one part (real or imaginary)
// Combines the feedforward sum with the feedback terms, rounds and
// saturates. The older feedback terms are summed ahead into a register so
// that only the newest output passes a multiplier inside the loop.
// ----------------------------------------------------------------------------
module cif_recur (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           step_i,
  input  logic           restart_i,
  input  cif_pkg::ff_t   ff_i,
  input  cif_pkg::samp_t y_tap_i [1:cif_pkg::ORDER],
  input  cif_pkg::coef_t den_i [1:cif_pkg::ORDER],
  output cif_pkg::samp_t y_o,
  output logic           clip_o
);

  cif_pkg::fb_t  fbs_d, fbs_q;
  cif_pkg::prod_t a1y;
  cif_pkg::acc_t acc;
  cif_pkg::sat_t res;

  // Older feedback terms for the next item: on a step the history moves by one
  always_comb begin
    cif_pkg::samp_t yop;
    cif_pkg::prod_t p;
    fbs_d = '0;
    for (int k = 2; k <= cif_pkg::ORDER; k++) begin
      yop   = step_i ? y_tap_i[k-1] : y_tap_i[k];
      p     = den_i[k] * yop;
      fbs_d = fbs_d + cif_pkg::fb_t'(p);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fbs_q <= '0;
    end else begin
      fbs_q <= fbs_d;
    end
  end

  // Loop path: newest output times a1, then round and saturate
  assign a1y = den_i[1] * y_tap_i[1];

  always_comb begin
    acc = cif_pkg::acc_t'(ff_i) - cif_pkg::acc_t'(a1y);
    if (!restart_i) begin
      acc = acc - cif_pkg::acc_t'(fbs_q);
    end
    res = cif_pkg::round_sat(acc);
  end

  assign y_o    = res.y;
  assign clip_o = res.clip;

endmodule

FILE: hdl/complex_iir_filter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_iir_filter: third-order direct-form-I IIR on complex samples
// Real and imaginary parts share real Q4.14 coefficients; samples are Q1.15.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries x_real, x_imag and a
//   restart flag that zeroes all history before its sample. Output channel
//   (out_valid_o / out_stall_i) returns y_real, y_imag and clipped, one
//   result per item, in order.
//   Coefficients are written through cfg_valid_i / cfg_index_i / cfg_data_i
//   (always ready) while no item is in flight: index 0..3 is b0..b3,
//   4..6 is a1..a3, higher indexes are ignored.
//   Throughput is one item per clock while out_stall_i is low. An item passes
//   three stages (products, feedforward sum, recursion into the output
//   register); out_valid_o rises as it enters the output register. The loop that
//   sets the rate is the a1 multiply, accumulate, round and saturate step.
//   When the receiver stalls, the result holds in the output register and
//   upstream stages keep filling any empty slot before in_stall_o rises.
//   Reset clears the history, sets b0 to 1.0 and the other coefficients
//   to zero and empties the pipeline.
// ----------------------------------------------------------------------------
module complex_iir_filter (
  input  logic           clk_i,
  input  logic           rst_ni,
  // input items
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  cif_pkg::samp_t x_real_i,
  input  cif_pkg::samp_t x_imag_i,
  input  logic           restart_i,
  // result items
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output cif_pkg::samp_t y_real_o,
  output cif_pkg::samp_t y_imag_o,
  output logic           clipped_o,
  // configuration writes
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  cif_pkg::reg_idx_t cfg_index_i,
  input  cif_pkg::coef_t   cfg_data_i
);

  localparam int ORDER = cif_pkg::ORDER;

  // Coefficient registers
  cif_pkg::coef_t num_q [0:cif_pkg::NUM_TAPS-1];
  cif_pkg::coef_t den_q [1:cif_pkg::DEN_TAPS];
  cif_pkg::coef_t den_use [1:ORDER];

  // Pipeline control
  logic v1_q, v2_q, v3_q;
  logic rst1_q, rst2_q;
  logic adv1, adv2, adv3, move1, move2, in_accept;
  logic y_clr;

  // Stage payloads
  cif_pkg::prod_t prod_re_q [0:ORDER];
  cif_pkg::prod_t prod_im_q [0:ORDER];
  cif_pkg::ff_t   ff_re_d, ff_im_d, ff_re_q, ff_im_q;
  cif_pkg::samp_t y_re_q, y_im_q;
  logic           clip_q;

  // Tap chain wiring
  cif_pkg::samp_t xr_tap [1:ORDER];
  cif_pkg::samp_t xi_tap [1:ORDER];
  cif_pkg::samp_t yr_tap [1:ORDER];
  cif_pkg::samp_t yi_tap [1:ORDER];
  cif_pkg::prod_t pr_tap [1:ORDER];
  cif_pkg::prod_t pi_tap [1:ORDER];

  cif_pkg::samp_t y_re_d, y_im_d;
  logic           clip_re, clip_im;

  // Configuration port
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q[0] <= cif_pkg::NUM_COEF_0_RESET;
      for (int k = 1; k < cif_pkg::NUM_TAPS; k++) begin
        num_q[k] <= '0;
      end
      for (int k = 1; k <= cif_pkg::DEN_TAPS; k++) begin
        den_q[k] <= '0;
      end
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        cif_pkg::REG_NUM_COEF_0: num_q[0] <= cfg_data_i;
        cif_pkg::REG_NUM_COEF_1: num_q[1] <= cfg_data_i;
        cif_pkg::REG_NUM_COEF_2: num_q[2] <= cfg_data_i;
        cif_pkg::REG_NUM_COEF_3: num_q[3] <= cfg_data_i;
        cif_pkg::REG_DEN_COEF_1: den_q[1] <= cfg_data_i;
        cif_pkg::REG_DEN_COEF_2: den_q[2] <= cfg_data_i;
        cif_pkg::REG_DEN_COEF_3: den_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int k = 1; k <= ORDER; k++) begin
      den_use[k] = den_q[k];
    end
  end

  // Handshake: each stage loads when empty or when it hands its item on
  assign adv3      = !v3_q || !out_stall_i;
  assign move2     = v2_q && adv3;
  assign adv2      = !v2_q || move2;
  assign move1     = v1_q && adv2;
  assign adv1      = !v1_q || move1;
  assign in_stall_o = !adv1;
  assign in_accept = in_valid_i && adv1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  // Output history is cleared for a restart item at the recursion stage
  assign y_clr = v2_q && rst2_q;

  // Chain of history cells
  for (genvar k = 1; k <= ORDER; k++) begin : g_tap
    cif_pkg::samp_t xr_in, xi_in, yr_in, yi_in;
    if (k == 1) begin : g_head
      assign xr_in = x_real_i;
      assign xi_in = x_imag_i;
      assign yr_in = y_re_d;
      assign yi_in = y_im_d;
    end else begin : g_body
      assign xr_in = xr_tap[k-1];
      assign xi_in = xi_tap[k-1];
      assign yr_in = yr_tap[k-1];
      assign yi_in = yi_tap[k-1];
    end

    cif_tap u_tap (
      .clk_i     (clk_i),
      .rst_ni    (rst_ni),
      .x_shift_i (in_accept),
      .x_clr_i   (restart_i),
      .y_shift_i (move2),
      .y_clr_i   (y_clr),
      .x_re_i    (xr_in),
      .x_im_i    (xi_in),
      .y_re_i    (yr_in),
      .y_im_i    (yi_in),
      .num_i     (num_q[k]),
      .x_re_o    (xr_tap[k]),
      .x_im_o    (xi_tap[k]),
      .y_re_o    (yr_tap[k]),
      .y_im_o    (yi_tap[k]),
      .prod_re_o (pr_tap[k]),
      .prod_im_o (pi_tap[k])
    );
  end

  // Stage 1: feedforward products of the accepted item
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      prod_re_q[0] <= num_q[0] * x_real_i;
      prod_im_q[0] <= num_q[0] * x_imag_i;
      for (int k = 1; k <= ORDER; k++) begin
        prod_re_q[k] <= pr_tap[k];
        prod_im_q[k] <= pi_tap[k];
      end
      rst1_q <= restart_i;
    end
  end

  // Stage 2: feedforward sum
  always_comb begin
    ff_re_d = '0;
    ff_im_d = '0;
    for (int k = 0; k <= ORDER; k++) begin
      ff_re_d = ff_re_d + cif_pkg::ff_t'(prod_re_q[k]);
      ff_im_d = ff_im_d + cif_pkg::ff_t'(prod_im_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (move1) begin
      ff_re_q <= ff_re_d;
      ff_im_q <= ff_im_d;
      rst2_q  <= rst1_q;
    end
  end

  // Stage 3: recursion per part into the output register
  cif_recur u_recur_re (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (move2),
    .restart_i (y_clr),
    .ff_i      (ff_re_q),
    .y_tap_i   (yr_tap),
    .den_i     (den_use),
    .y_o       (y_re_d),
    .clip_o    (clip_re)
  );

  cif_recur u_recur_im (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (move2),
    .restart_i (y_clr),
    .ff_i      (ff_im_q),
    .y_tap_i   (yi_tap),
    .den_i     (den_use),
    .y_o       (y_im_d),
    .clip_o    (clip_im)
  );

  always_ff @(posedge clk_i) begin
    if (move2) begin
      y_re_q <= y_re_d;
      y_im_q <= y_im_d;
      clip_q <= clip_re || clip_im;
    end
  end

  assign out_valid_o = v3_q;
  assign y_real_o    = y_re_q;
  assign y_imag_o    = y_im_q;
  assign clipped_o   = clip_q;

endmodule
